FILE: rtl/core/variable_length_message_fifo_assert.svh
// Assertion macros for the variable-length message FIFO checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef VARIABLE_LENGTH_MESSAGE_FIFO_ASSERT_SVH
`define VARIABLE_LENGTH_MESSAGE_FIFO_ASSERT_SVH

// Same-cycle implication, muted during reset.
`define VLMF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vlmf check failed: same-cycle rule");

// Next-cycle implication, muted during reset.
`define VLMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vlmf check failed: next-cycle rule");

`endif

FILE: rtl/core/vlmf_pkg.sv
// Shared widths and codes for the variable-length message FIFO.
// No dependencies; used by the top level and its checker.
`default_nettype none

package vlmf_pkg;

  localparam int LEN_W    = 13;
  localparam int BYTE_W   = 8;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;

  localparam logic [ACTION_W-1:0] ACT_ENQ  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DEQ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_PEEK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;

  localparam logic [LEN_W-1:0] CAP_RESET = 13'd4096;

endpackage

`default_nettype wire

FILE: rtl/core/variable_length_message_fifo.sv
// Variable-length message FIFO: byte ring plus message length queue, both in
// synchronous memories. Depends on vlmf_pkg.
`default_nettype none

// Usage
// - Input channel (in_valid/in_ready): one item per request. in_action picks
//   enqueue one byte, dequeue one byte or peek. in_msg_length is sampled only
//   on the first byte of a message; a message whose length is zero, does not
//   fit the byte capacity, or finds the length queue full is dropped whole.
// - Result channel (out_valid/out_ready): exactly one item per request,
//   carrying status, dequeued byte, last-byte mark, head length and the
//   count of complete messages after the request.
// - Config channel (cfg_valid/cfg_ready): writes the byte capacity; always
//   ready. Write it only while no request is in flight.
// - Each request passes through states IDLE, EXEC and HEAD; a new request is
//   taken only in IDLE. The memories have registered reads: IDLE reads the
//   byte and head length, EXEC executes and writes back, HEAD rereads the
//   new head length and waits while the output register is stalled.
// - Reset clears pointers, counters and capacity (4096); memory contents are
//   undefined until written and need no clearing pass.
// - When the receiver stalls, hold the finished result in the output
//   register; the next request may already be taken and waits for it.
module variable_length_message_fifo #(
  parameter int BUFFER_BYTES = 4096,
  parameter int MAX_MESSAGES = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [vlmf_pkg::LEN_W-1:0]           cfg_capacity_bytes,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [vlmf_pkg::ACTION_W-1:0]        in_action,
  input  wire logic [vlmf_pkg::BYTE_W-1:0]          in_data_byte,
  input  wire logic [vlmf_pkg::LEN_W-1:0]           in_msg_length,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [vlmf_pkg::STATUS_W-1:0]             out_status,
  output logic [vlmf_pkg::BYTE_W-1:0]               out_out_byte,
  output logic                                      out_last_byte,
  output logic [vlmf_pkg::LEN_W-1:0]                out_head_length,
  output logic [$clog2(MAX_MESSAGES+1)-1:0]         out_message_count
);
  import vlmf_pkg::*;

  localparam int PW = $clog2(BUFFER_BYTES);      // byte ring address
  localparam int CW = $clog2(BUFFER_BYTES + 1);  // stored byte count
  localparam int QW = $clog2(MAX_MESSAGES);      // length queue address
  localparam int HW = $clog2(MAX_MESSAGES + 1);  // message count
  localparam int SW = ((CW > LEN_W) ? CW : LEN_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_HEAD = 3'b100
  } state_t;

  // Storage
  logic [BYTE_W-1:0] byte_mem [BUFFER_BYTES];
  logic [LEN_W-1:0]  len_mem  [MAX_MESSAGES];
  logic [BYTE_W-1:0] byte_rd_r;
  logic [LEN_W-1:0]  len_rd_r;
  logic              byte_we;
  logic              len_we;

  // Control state
  state_t            state_r, state_nxt;
  logic [PW-1:0]     wp_r, wp_nxt;
  logic [PW-1:0]     rp_r, rp_nxt;
  logic [CW-1:0]     stored_r, stored_nxt;
  logic [QW-1:0]     head_r, head_nxt;
  logic [QW-1:0]     tail_r, tail_nxt;
  logic [HW-1:0]     held_r, held_nxt;
  logic [LEN_W-1:0]  enq_rem_r, enq_rem_nxt;
  logic              enq_drop_r, enq_drop_nxt;
  logic [LEN_W-1:0]  deq_rem_r, deq_rem_nxt;
  logic [LEN_W-1:0]  cap_r, cap_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload registers
  logic [ACTION_W-1:0] action_r, action_nxt;
  logic [BYTE_W-1:0]   data_r, data_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [BYTE_W-1:0]   res_byte_r, res_byte_nxt;
  logic                res_last_r, res_last_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                out_last_r, out_last_nxt;
  logic [LEN_W-1:0]    out_head_r, out_head_nxt;
  logic [HW-1:0]       out_count_r, out_count_nxt;

  // Enqueue / dequeue helpers
  logic [SW-1:0]    limit;
  logic [SW-1:0]    need;
  logic             enq_start;
  logic             reject;
  logic [LEN_W-1:0] enq_base;
  logic [LEN_W-1:0] enq_dec;
  logic [LEN_W-1:0] deq_base;
  logic [LEN_W-1:0] deq_dec;
  logic             out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_out_byte      = out_byte_r;
  assign out_last_byte     = out_last_r;
  assign out_head_length   = out_head_r;
  assign out_message_count = out_count_r;

  // Limit in force is the smaller of the register and the ring size.
  // need > limit covers both an oversized length and a full ring.
  assign limit = (SW'(cap_r) < SW'(BUFFER_BYTES)) ? SW'(cap_r) : SW'(BUFFER_BYTES);
  assign need  = SW'(stored_r) + SW'(len_r);

  assign enq_start = (enq_rem_r == '0);
  assign reject    = (len_r == '0) || (need > limit) || (held_r == HW'(MAX_MESSAGES));
  assign enq_base  = enq_start ? len_r : enq_rem_r;
  assign enq_dec   = enq_base - LEN_W'(1);

  // Length of the head message comes from memory on its first byte out.
  assign deq_base = (deq_rem_r == '0) ? len_rd_r : deq_rem_r;
  assign deq_dec  = (deq_base != '0) ? (deq_base - LEN_W'(1)) : '0;

  assign out_load = (state_r == S_HEAD) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    wp_nxt         = wp_r;
    rp_nxt         = rp_r;
    stored_nxt     = stored_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    held_nxt       = held_r;
    enq_rem_nxt    = enq_rem_r;
    enq_drop_nxt   = enq_drop_r;
    deq_rem_nxt    = deq_rem_r;
    cap_nxt        = cap_r;
    action_nxt     = action_r;
    data_nxt       = data_r;
    len_nxt        = len_r;
    res_status_nxt = res_status_r;
    res_byte_nxt   = res_byte_r;
    res_last_nxt   = res_last_r;
    out_status_nxt = out_status_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_head_nxt   = out_head_r;
    out_count_nxt  = out_count_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    byte_we        = 1'b0;
    len_we         = 1'b0;

    if (cfg_valid) begin
      cap_nxt = cfg_capacity_bytes;
    end

    unique case (state_r)
      S_IDLE: begin
        // Capture the request; memory reads at the current pointers go out now.
        if (in_valid) begin
          action_nxt = in_action;
          data_nxt   = in_data_byte;
          len_nxt    = in_msg_length;
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        res_status_nxt = ST_OK;
        res_byte_nxt   = '0;
        res_last_nxt   = 1'b0;
        case (action_r)
          ACT_ENQ: begin
            if (enq_start && reject) begin
              // Drop the whole message; a length of zero or one ends here.
              res_status_nxt = ST_REJECT;
              if (len_r <= LEN_W'(1)) begin
                res_last_nxt = 1'b1;
                enq_drop_nxt = 1'b0;
              end else begin
                enq_rem_nxt  = enq_dec;
                enq_drop_nxt = 1'b1;
              end
            end else if (!enq_start && enq_drop_r) begin
              res_status_nxt = ST_REJECT;
              enq_rem_nxt    = enq_dec;
              if (enq_dec == '0) begin
                enq_drop_nxt = 1'b0;
                res_last_nxt = 1'b1;
              end
            end else begin
              if (enq_start) begin
                // Reserve the whole message and queue its length.
                enq_drop_nxt = 1'b0;
                stored_nxt   = need[CW-1:0];
                len_we       = 1'b1;
              end
              byte_we     = 1'b1;
              wp_nxt      = (wp_r == PW'(BUFFER_BYTES - 1)) ? '0 : wp_r + PW'(1);
              enq_rem_nxt = enq_dec;
              if (enq_dec == '0) begin
                tail_nxt     = (tail_r == QW'(MAX_MESSAGES - 1)) ? '0 : tail_r + QW'(1);
                held_nxt     = held_r + HW'(1);
                res_last_nxt = 1'b1;
              end
            end
          end
          ACT_DEQ: begin
            if (held_r == '0) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              res_byte_nxt = byte_rd_r;
              rp_nxt       = (rp_r == PW'(BUFFER_BYTES - 1)) ? '0 : rp_r + PW'(1);
              if (stored_r != '0) begin
                stored_nxt = stored_r - CW'(1);
              end
              deq_rem_nxt = deq_dec;
              if (deq_dec == '0) begin
                head_nxt     = (head_r == QW'(MAX_MESSAGES - 1)) ? '0 : head_r + QW'(1);
                held_nxt     = held_r - HW'(1);
                res_last_nxt = 1'b1;
              end
            end
          end
          ACT_PEEK: begin
            if (held_r == '0) begin
              res_status_nxt = ST_EMPTY;
            end
          end
          default: begin
          end
        endcase
        state_nxt = S_HEAD;
      end

      S_HEAD: begin
        // The head length reread at the updated head pointer is ready here.
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_byte_nxt   = res_byte_r;
          out_last_nxt   = res_last_r;
          out_head_nxt   = (held_r != '0) ? len_rd_r : '0;
          out_count_nxt  = held_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Byte ring: write at the tail, read at the read pointer.
  always_ff @(posedge clk) begin
    if (byte_we) begin
      byte_mem[wp_r] <= data_r;
    end
    byte_rd_r <= byte_mem[rp_r];
  end

  // Length queue: read at the next head pointer. A one-byte message into an
  // empty queue writes the very slot being read; forward the new length.
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[tail_r] <= len_r;
    end
    if (len_we && (tail_r == head_nxt)) begin
      len_rd_r <= len_r;
    end else begin
      len_rd_r <= len_mem[head_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      stored_r    <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      held_r      <= '0;
      enq_rem_r   <= '0;
      enq_drop_r  <= 1'b0;
      deq_rem_r   <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      stored_r    <= stored_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      held_r      <= held_nxt;
      enq_rem_r   <= enq_rem_nxt;
      enq_drop_r  <= enq_drop_nxt;
      deq_rem_r   <= deq_rem_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r     <= action_nxt;
    data_r       <= data_nxt;
    len_r        <= len_nxt;
    res_status_r <= res_status_nxt;
    res_byte_r   <= res_byte_nxt;
    res_last_r   <= res_last_nxt;
    out_status_r <= out_status_nxt;
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
    out_head_r   <= out_head_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/core/vlmf_checker.sv
// Port-level checks for the variable-length message FIFO, bound to the top.
// Depends on vlmf_pkg and variable_length_message_fifo_assert.svh.
`default_nettype none

`include "variable_length_message_fifo_assert.svh"

module vlmf_checker #(
  parameter int MAX_MESSAGES = 64
) (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_valid,
  input wire logic                                 in_ready,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic [vlmf_pkg::STATUS_W-1:0]        out_status,
  input wire logic [vlmf_pkg::BYTE_W-1:0]          out_out_byte,
  input wire logic                                 out_last_byte,
  input wire logic [vlmf_pkg::LEN_W-1:0]           out_head_length,
  input wire logic [$clog2(MAX_MESSAGES+1)-1:0]    out_message_count
);
  import vlmf_pkg::*;

  logic                              in_take;
  logic                              out_stall;
  logic                              out_empty;
  logic                              out_none;
  logic                              out_fault;
  logic [STATUS_W+BYTE_W+LEN_W:0]    out_payload;

  assign in_take     = in_valid && in_ready;
  assign out_stall   = out_valid && !out_ready;
  assign out_empty   = out_valid && (out_status == ST_EMPTY);
  assign out_none    = out_valid && (out_message_count == '0);
  assign out_fault   = out_valid && (out_status != ST_OK);
  assign out_payload = {out_status, out_out_byte, out_last_byte, out_head_length};

  // Hold a stalled result unchanged.
  `VLMF_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_payload))

  // An empty queue reports no head and no messages.
  `VLMF_ASSERT_NOW(a_empty_no_head, out_empty, out_message_count == '0 && out_head_length == '0)

  // No messages means no head length.
  `VLMF_ASSERT_NOW(a_count_zero_head, out_none, out_head_length == '0)

  // Only a successful request can carry a dequeued byte.
  `VLMF_ASSERT_NOW(a_byte_only_ok, out_fault, out_out_byte == '0)

  // One request at a time: accepting an item closes the input.
  `VLMF_ASSERT_NEXT(a_one_in_flight, in_take, !in_ready)

endmodule

bind variable_length_message_fifo vlmf_checker #(
  .MAX_MESSAGES(MAX_MESSAGES)
) u_vlmf_checker (.*);

`default_nettype wire
